### hw/rtl/cwg_pkg.sv
// Shared constants, types and codes of the causal window gather block.
package cwg_pkg;

    // Sizing of the line store and of the neighborhood mask
    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_MASK_ROWS = 4;
    localparam int MAX_MASK_COLS = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int MASK_STRIDE   = 16;
    localparam int MASK_W        = 64;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int SLOT_W      = $clog2(MAX_MASK_ROWS);
    localparam int ADDR_W      = SLOT_W + COL_W;
    localparam int STORE_DEPTH = MAX_MASK_ROWS * MAX_WIDTH;
    localparam int STRIDE_W    = $clog2(MASK_STRIDE);
    localparam int EIDX_W      = $clog2(MASK_W);
    localparam int MROW_W      = EIDX_W - STRIDE_W;
    localparam int COLX_W      = COL_W + 2;

    // Field widths
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int ROWS_W     = 3;
    localparam int COLS_W     = 5;
    localparam int ACOL_W     = 4;
    localparam int AROW_W     = 2;
    localparam int PIX_W      = 16;
    localparam int OFFR_W     = 3;
    localparam int OFFC_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Queue depths
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    typedef logic [WIDTH_W-1:0]     t_width;
    typedef logic [HEIGHT_W-1:0]    t_height;
    typedef logic [MASK_W-1:0]      t_mask;
    typedef logic [ROWS_W-1:0]      t_rows;
    typedef logic [COLS_W-1:0]      t_cols;
    typedef logic [ACOL_W-1:0]      t_acol;
    typedef logic [AROW_W-1:0]      t_arow;
    typedef logic [COL_W-1:0]       t_col;
    typedef logic [COLX_W-1:0]      t_colx;
    typedef logic [SLOT_W-1:0]      t_slot;
    typedef logic [ADDR_W-1:0]      t_addr;
    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [PIX_W-1:0]       t_pix;
    typedef logic [OFFR_W-1:0]      t_offr;
    typedef logic [OFFC_W-1:0]      t_offc;
    typedef logic [EIDX_W-1:0]      t_eidx;
    typedef logic [MROW_W-1:0]      t_mrow;
    typedef logic [STRIDE_W-1:0]    t_mcol;
    typedef logic [QPTR_W-1:0]      t_qptr;
    typedef logic [QCNT_W-1:0]      t_qcnt;
    typedef logic [OPTR_W-1:0]      t_optr;
    typedef logic [OCNT_W-1:0]      t_ocnt;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_MASK_BITS    = 3'd2,
        REG_MASK_ROWS    = 3'd3,
        REG_MASK_COLS    = 3'd4,
        REG_ANCHOR_COL   = 3'd5,
        REG_ANCHOR_ROW   = 3'd6
    } t_cfg_reg;

    // Configuration as seen by the datapath, sizes already clamped
    typedef struct packed {
        t_width  width;
        t_height height;
        t_mask   mask;
        t_rows   rows;
        t_cols   cols;
        t_acol   acol;
        t_arow   arow;
    } t_cfg;

    // One classified sample on its way from front to back
    typedef struct packed {
        t_sample pixel;
        t_slot   slot;
        t_col    col;
        t_mask   elem;
    } t_item;

    // One neighbor beat
    typedef struct packed {
        t_pix  sample;
        t_offr offr;
        t_offc offc;
        logic  last;
    } t_result;

endpackage

### hw/rtl/cwg_if.sv
// Handshake channels of the causal window gather block.
interface cwg_pix_if;
    logic            valid;
    logic            ready;
    cwg_pkg::t_pix   pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

interface cwg_res_if;
    logic            valid;
    logic            ready;
    cwg_pkg::t_pix   sample_value;
    cwg_pkg::t_offr  offset_row;
    cwg_pkg::t_offc  offset_col;
    logic            last_element;

    modport source (output valid, output sample_value, output offset_row,
                    output offset_col, output last_element, input ready);
    modport sink   (input valid, input sample_value, input offset_row,
                    input offset_col, input last_element, output ready);
endinterface

interface cwg_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [cwg_pkg::CFG_IDX_W-1:0]         index;
    logic [cwg_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/cwg_ram.sv
// Generic simple dual-port RAM with registered read, old data on collision.
module cwg_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/cwg_front.sv
// Front end: accepts samples, tracks the raster position, marks usable mask elements.
module cwg_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cwg_pkg::t_cfg    i_cfg,
    cwg_pix_if.sink          i_pix,
    output logic             o_push_valid,
    output cwg_pkg::t_item   o_push_item,
    input  logic             i_push_ready
);

    cwg_pkg::t_col    r_col, n_col;
    cwg_pkg::t_height r_row, n_row;
    cwg_pkg::t_col    col0;
    cwg_pkg::t_height row0;
    logic [cwg_pkg::WIDTH_W-1:0]  col_inc;
    logic [cwg_pkg::HEIGHT_W:0]   row_inc;
    logic [cwg_pkg::MAX_MASK_ROWS-1:0] row_ok;
    logic [cwg_pkg::MAX_MASK_COLS-1:0] col_ok;
    cwg_pkg::t_mask   elem;
    logic             accept;

    // Position of this sample: wrap first if a size shrank under the counters
    always_comb begin
        col0 = r_col;
        row0 = r_row;
        if (cwg_pkg::t_width'(r_col) >= i_cfg.width) begin
            col0 = '0;
            row0 = r_row + 1'b1;
        end
        if (row0 >= i_cfg.height) begin
            row0 = '0;
        end
    end

    // Position of the next sample
    always_comb begin
        col_inc = cwg_pkg::t_width'(col0) + 1'b1;
        row_inc = {1'b0, row0} + 1'b1;
        n_col   = col_inc[cwg_pkg::COL_W-1:0];
        n_row   = row0;
        if (col_inc >= i_cfg.width) begin
            n_col = '0;
            n_row = (row_inc >= {1'b0, i_cfg.height}) ? '0
                                                      : row_inc[cwg_pkg::HEIGHT_W-1:0];
        end
    end

    // Mask rows that lie inside the image and not below the anchor
    always_comb begin
        for (int r = 0; r < cwg_pkg::MAX_MASK_ROWS; r++) begin
            row_ok[r] = (cwg_pkg::t_rows'(r) < i_cfg.rows) &&
                        (cwg_pkg::t_rows'(r) <= cwg_pkg::t_rows'(i_cfg.arow)) &&
                        (row0 >= (cwg_pkg::t_height'(i_cfg.arow) - cwg_pkg::t_height'(r)));
        end
    end

    // Mask columns that land inside the current row
    always_comb begin
        for (int c = 0; c < cwg_pkg::MAX_MASK_COLS; c++) begin
            col_ok[c] = (cwg_pkg::t_cols'(c) < i_cfg.cols) &&
                        ((cwg_pkg::t_colx'(col0) + cwg_pkg::t_colx'(c)) >=
                         cwg_pkg::t_colx'(i_cfg.acol)) &&
                        ((cwg_pkg::t_colx'(col0) + cwg_pkg::t_colx'(c)) <
                         (cwg_pkg::t_colx'(i_cfg.width) + cwg_pkg::t_colx'(i_cfg.acol)));
        end
    end

    // Drop set bits that fall outside the image or come after the anchor
    always_comb begin
        elem = '0;
        for (int r = 0; r < cwg_pkg::MAX_MASK_ROWS; r++) begin
            for (int c = 0; c < cwg_pkg::MAX_MASK_COLS; c++) begin
                if (r * cwg_pkg::MASK_STRIDE + c < cwg_pkg::MASK_W) begin
                    elem[r * cwg_pkg::MASK_STRIDE + c] =
                        i_cfg.mask[r * cwg_pkg::MASK_STRIDE + c] && row_ok[r] && col_ok[c] &&
                        !((cwg_pkg::t_rows'(r) == cwg_pkg::t_rows'(i_cfg.arow)) &&
                          (cwg_pkg::t_colx'(c) > cwg_pkg::t_colx'(i_cfg.acol)));
                end
            end
        end
    end

    assign accept       = i_pix.valid && i_push_ready;
    assign i_pix.ready  = i_push_ready;
    assign o_push_valid = i_pix.valid;

    always_comb begin
        o_push_item.pixel = i_pix.pixel_value[cwg_pkg::SAMPLE_BITS-1:0];
        o_push_item.slot  = row0[cwg_pkg::SLOT_W-1:0];
        o_push_item.col   = col0;
        o_push_item.elem  = elem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

### hw/rtl/cwg_queue.sv
// Short queue of classified samples between front and back.
module cwg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  cwg_pkg::t_item i_push_item,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output cwg_pkg::t_item o_pop_item,
    input  logic           i_pop_ready
);

    cwg_pkg::t_item r_mem [cwg_pkg::QUEUE_DEPTH];
    cwg_pkg::t_qptr r_wr_ptr, r_rd_ptr;
    cwg_pkg::t_qcnt r_cnt;
    logic           push, pop;

    assign o_push_ready = (r_cnt != cwg_pkg::t_qcnt'(cwg_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == cwg_pkg::t_qptr'(cwg_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == cwg_pkg::t_qptr'(cwg_pkg::QUEUE_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

### hw/rtl/cwg_back.sv
// Back end: stores each sample, then reads out one marked neighbor per cycle while the output queue has room.
module cwg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cwg_pkg::t_cfg  i_cfg,
    input  logic           i_pop_valid,
    input  cwg_pkg::t_item i_pop_item,
    output logic           o_pop_ready,
    cwg_res_if.source      o_res
);

    // Gather state
    logic              r_busy;
    cwg_pkg::t_mask    r_elem;
    cwg_pkg::t_slot    r_slot;
    cwg_pkg::t_col     r_col;

    cwg_pkg::t_mask    lowest, rest;
    cwg_pkg::t_eidx    idx;
    cwg_pkg::t_mrow    mrow;
    cwg_pkg::t_mcol    mcol;
    cwg_pkg::t_addr    rd_addr;
    cwg_pkg::t_sample  rd_data;
    logic              last, issue, load;

    // Read stage
    logic              r_s1_valid;
    cwg_pkg::t_offr    r_s1_offr;
    cwg_pkg::t_offc    r_s1_offc;
    logic              r_s1_last;

    // Output queue
    cwg_pkg::t_result  r_out [cwg_pkg::OUT_DEPTH];
    cwg_pkg::t_optr    r_wr_ptr, r_rd_ptr;
    cwg_pkg::t_ocnt    r_cnt;
    cwg_pkg::t_result  out_head, out_push;
    logic              out_pop;

    // Lowest marked element
    assign lowest = r_elem & (~r_elem + 1'b1);
    assign rest   = r_elem & ~lowest;
    assign last   = (rest == '0);

    always_comb begin
        idx = '0;
        for (int k = 0; k < cwg_pkg::MASK_W; k++) begin
            if (lowest[k]) begin
                idx = idx | cwg_pkg::t_eidx'(k);
            end
        end
    end

    assign mrow = idx[cwg_pkg::EIDX_W-1:cwg_pkg::STRIDE_W];
    assign mcol = idx[cwg_pkg::STRIDE_W-1:0];

    assign rd_addr = {r_slot + cwg_pkg::t_slot'(mrow) - cwg_pkg::t_slot'(i_cfg.arow),
                      r_col + cwg_pkg::t_col'(mcol) - cwg_pkg::t_col'(i_cfg.acol)};

    // Issue only while the output queue can absorb what is in flight
    assign issue = r_busy && (r_cnt <= cwg_pkg::t_ocnt'(cwg_pkg::OUT_DEPTH - 2));
    assign o_pop_ready = !r_busy || (issue && last);
    assign load        = i_pop_valid && o_pop_ready;

    cwg_ram #(
        .WIDTH (cwg_pkg::SAMPLE_BITS),
        .DEPTH (cwg_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (load),
        .i_wr_addr ({i_pop_item.slot, i_pop_item.col}),
        .i_wr_data (i_pop_item.pixel),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= issue;
            if (load) begin
                r_busy <= (i_pop_item.elem != '0);
            end else if (issue && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_elem <= i_pop_item.elem;
            r_slot <= i_pop_item.slot;
            r_col  <= i_pop_item.col;
        end else if (issue) begin
            r_elem <= rest;
        end
        if (issue) begin
            r_s1_offr <= cwg_pkg::t_offr'(mrow) - cwg_pkg::t_offr'(i_cfg.arow);
            r_s1_offc <= cwg_pkg::t_offc'(mcol) - cwg_pkg::t_offc'(i_cfg.acol);
            r_s1_last <= last;
        end
    end

    // Output queue
    always_comb begin
        out_push.sample = cwg_pkg::t_pix'(rd_data);
        out_push.offr   = r_s1_offr;
        out_push.offc   = r_s1_offc;
        out_push.last   = r_s1_last;
    end

    assign out_head           = r_out[r_rd_ptr];
    assign o_res.valid        = (r_cnt != '0);
    assign o_res.sample_value = out_head.sample;
    assign o_res.offset_row   = out_head.offr;
    assign o_res.offset_col   = out_head.offc;
    assign o_res.last_element = out_head.last;
    assign out_pop            = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (r_s1_valid) begin
                r_wr_ptr <= (r_wr_ptr == cwg_pkg::t_optr'(cwg_pkg::OUT_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (out_pop) begin
                r_rd_ptr <= (r_rd_ptr == cwg_pkg::t_optr'(cwg_pkg::OUT_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            if (r_s1_valid && !out_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (out_pop && !r_s1_valid) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_out[r_wr_ptr] <= out_push;
        end
    end

    // A busy sequencer always has an element left to read
    a_busy_has_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_elem != '0))
        else $error("gather busy with no marked element");

    // Every read lands in the read stage in the next cycle
    a_issue_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> r_s1_valid)
        else $error("read issued but read stage empty");

    // Read data always finds room in the output queue
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_cnt < cwg_pkg::t_ocnt'(cwg_pkg::OUT_DEPTH)))
        else $error("output queue overflow");

endmodule

### hw/rtl/causal_window_gather.sv
// Top level of the causal window gather block: configuration registers and wiring.
//
// Samples arrive in raster order on i_pix, one beat per sample. For every
// sample the block sends on o_res one beat per neighbor under a set bit of
// the configured mask (mask rows top to bottom, columns left to right),
// with the neighbor's row and column offset from the current position; the
// last beat of a sample carries last_element. Neighbors off the image edge,
// above row 0 or after the current sample in raster order are dropped; a
// sample with no surviving neighbor sends nothing.
// The back end makes one line store read per cycle, one per neighbor, while
// its output queue has room. The front end keeps accepting into a two-entry
// queue while the back end works; a stalled o_res fills a four-entry output
// queue, then holds the back end and in turn the front end. No result is lost
// while stalled. i_cfg is always ready; write it only while the block is idle.
// Reset clears the position to row 0, column 0 and loads the register
// defaults (width 1024, height 1024, empty 1x1 mask, anchor 0,0). The line
// store is not cleared; a slot never written since power-up reads undefined,
// which only a width change in the middle of a frame can reach.
module causal_window_gather (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cwg_pix_if.sink  i_pix,
    cwg_res_if.source o_res,
    cwg_cfg_if.sink  i_cfg
);

    cwg_pkg::t_width  r_width;
    cwg_pkg::t_height r_height;
    cwg_pkg::t_mask   r_mask;
    cwg_pkg::t_rows   r_rows;
    cwg_pkg::t_cols   r_cols;
    cwg_pkg::t_acol   r_acol;
    cwg_pkg::t_arow   r_arow;
    cwg_pkg::t_cfg    cfg;

    logic             push_valid, push_ready, pop_valid, pop_ready;
    cwg_pkg::t_item   push_item, pop_item;

    assign i_cfg.ready = 1'b1;

    // Register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= cwg_pkg::t_width'(1024);
            r_height <= cwg_pkg::t_height'(1024);
            r_mask   <= '0;
            r_rows   <= cwg_pkg::t_rows'(1);
            r_cols   <= cwg_pkg::t_cols'(1);
            r_acol   <= '0;
            r_arow   <= '0;
        end else if (i_cfg.valid) begin
            unique case (cwg_pkg::t_cfg_reg'(i_cfg.index))
                cwg_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg.data[cwg_pkg::WIDTH_W-1:0];
                cwg_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg.data[cwg_pkg::HEIGHT_W-1:0];
                cwg_pkg::REG_MASK_BITS:    r_mask   <= i_cfg.data[cwg_pkg::MASK_W-1:0];
                cwg_pkg::REG_MASK_ROWS:    r_rows   <= i_cfg.data[cwg_pkg::ROWS_W-1:0];
                cwg_pkg::REG_MASK_COLS:    r_cols   <= i_cfg.data[cwg_pkg::COLS_W-1:0];
                cwg_pkg::REG_ANCHOR_COL:   r_acol   <= i_cfg.data[cwg_pkg::ACOL_W-1:0];
                cwg_pkg::REG_ANCHOR_ROW:   r_arow   <= i_cfg.data[cwg_pkg::AROW_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Clamp sizes: zero counts as one, oversize as the maximum
    always_comb begin
        cfg.width = r_width;
        if (r_width == '0) begin
            cfg.width = cwg_pkg::t_width'(1);
        end else if (r_width > cwg_pkg::t_width'(cwg_pkg::MAX_WIDTH)) begin
            cfg.width = cwg_pkg::t_width'(cwg_pkg::MAX_WIDTH);
        end
        cfg.height = (r_height == '0) ? cwg_pkg::t_height'(1) : r_height;
        cfg.rows = r_rows;
        if (r_rows == '0) begin
            cfg.rows = cwg_pkg::t_rows'(1);
        end else if (r_rows > cwg_pkg::t_rows'(cwg_pkg::MAX_MASK_ROWS)) begin
            cfg.rows = cwg_pkg::t_rows'(cwg_pkg::MAX_MASK_ROWS);
        end
        cfg.cols = r_cols;
        if (r_cols == '0) begin
            cfg.cols = cwg_pkg::t_cols'(1);
        end else if (r_cols > cwg_pkg::t_cols'(cwg_pkg::MAX_MASK_COLS)) begin
            cfg.cols = cwg_pkg::t_cols'(cwg_pkg::MAX_MASK_COLS);
        end
        cfg.mask = r_mask;
        cfg.acol = r_acol;
        cfg.arow = r_arow;
    end

    // Front end: position tracking and element classification
    cwg_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_pix        (i_pix),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    // Decouple front and back
    cwg_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    // Back end: line store write, neighbor reads, output queue
    cwg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .o_res       (o_res)
    );

endmodule

### tb/cwg_gather_checker.sv
`timescale 1ns / 1ps
// Passive checker that predicts and compares the neighbor beats of the window gather.
module cwg_gather_checker
    import cwg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    cwg_pix_if   i_pix,
    cwg_res_if   i_res,
    cwg_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int REPORT_LIMIT = 10;

    t_width  reg_width;
    t_height reg_height;
    t_mask   reg_mask;
    t_rows   reg_rows;
    t_cols   reg_cols;
    t_acol   reg_acol;
    t_arow   reg_arow;

    t_pix    line_store [STORE_DEPTH];
    bit      written    [STORE_DEPTH];
    int      col_pos;
    int      row_pos;
    t_result neighbor_q [$];
    bit      known_q    [$];
    int      fail_count;

    function automatic int clamp(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int slot_of(input int row, input int col);
        return (row % MAX_MASK_ROWS) * MAX_WIDTH + (col % MAX_WIDTH);
    endfunction

    // Store the sample, then queue every surviving neighbor in mask order.
    // A neighbor slot never written since reset has no defined sample.
    task automatic gather_neighbors(input t_pix px);
        int      w, h, nrows, ncols, r, c, dr, dc, ny, nx, bit_idx;
        bit      have_prev, known, prev_known;
        t_result beat, prev;
        w          = clamp(int'(reg_width), 1, MAX_WIDTH);
        h          = (reg_height == '0) ? 1 : int'(reg_height);
        nrows      = clamp(int'(reg_rows), 1, MAX_MASK_ROWS);
        ncols      = clamp(int'(reg_cols), 1, MAX_MASK_COLS);
        have_prev  = 1'b0;
        prev_known = 1'b0;
        prev       = '0;

        // a shrunken frame pushes the position on before the sample lands
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1) & 16'hFFFF;
        end
        if (row_pos >= h)
            row_pos = 0;

        line_store[slot_of(row_pos, col_pos)] = px;
        written[slot_of(row_pos, col_pos)]    = 1'b1;

        for (r = 0; r < nrows; r++) begin
            dr = r - int'(reg_arow);
            ny = row_pos + dr;
            if (dr > 0 || ny < 0)
                continue;
            for (c = 0; c < ncols; c++) begin
                dc      = c - int'(reg_acol);
                nx      = col_pos + dc;
                bit_idx = r * MASK_STRIDE + c;
                if (bit_idx >= MASK_W || !reg_mask[bit_idx])
                    continue;
                if (nx < 0 || nx >= w)
                    continue;
                if (dr == 0 && dc > 0)
                    continue;
                beat.sample = line_store[slot_of(ny, nx)];
                beat.offr   = t_offr'(dr);
                beat.offc   = t_offc'(dc);
                beat.last   = 1'b0;
                known       = written[slot_of(ny, nx)];
                if (have_prev) begin
                    neighbor_q.push_back(prev);
                    known_q.push_back(prev_known);
                end
                prev       = beat;
                prev_known = known;
                have_prev  = 1'b1;
            end
        end
        if (have_prev) begin
            prev.last = 1'b1;
            neighbor_q.push_back(prev);
            known_q.push_back(prev_known);
        end

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    task automatic compare_beat();
        t_result want, got;
        bit      want_known;
        got.sample = i_res.sample_value;
        got.offr   = i_res.offset_row;
        got.offc   = i_res.offset_col;
        got.last   = i_res.last_element;
        if (neighbor_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("%0t: unexpected neighbor beat: sample %h row %0d col %0d last %b",
                         $time, got.sample, $signed(got.offr), $signed(got.offc), got.last);
        end else begin
            want       = neighbor_q.pop_front();
            want_known = known_q.pop_front();
            if ((want_known && got.sample !== want.sample) || got.offr !== want.offr ||
                got.offc !== want.offc || got.last !== want.last) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("%0t: neighbor beat mismatch", $time);
                    $display("  expected sample %h row %0d col %0d last %b",
                             want.sample, $signed(want.offr), $signed(want.offc), want.last);
                    $display("  got      sample %h row %0d col %0d last %b",
                             got.sample, $signed(got.offr), $signed(got.offc), got.last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_width  = t_width'(MAX_WIDTH);
            reg_height = t_height'(1024);
            reg_mask   = '0;
            reg_rows   = t_rows'(1);
            reg_cols   = t_cols'(1);
            reg_acol   = '0;
            reg_arow   = '0;
            col_pos    = 0;
            row_pos    = 0;
            fail_count = 0;
            foreach (written[k])
                written[k] = 1'b0;
            neighbor_q.delete();
            known_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_IMAGE_WIDTH:  reg_width  = t_width'(i_cfg.data);
                    REG_IMAGE_HEIGHT: reg_height = t_height'(i_cfg.data);
                    REG_MASK_BITS:    reg_mask   = t_mask'(i_cfg.data);
                    REG_MASK_ROWS:    reg_rows   = t_rows'(i_cfg.data);
                    REG_MASK_COLS:    reg_cols   = t_cols'(i_cfg.data);
                    REG_ANCHOR_COL:   reg_acol   = t_acol'(i_cfg.data);
                    REG_ANCHOR_ROW:   reg_arow   = t_arow'(i_cfg.data);
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready)
                gather_neighbors(i_pix.pixel_value);
            if (i_res.valid && i_res.ready)
                compare_beat();
        end
        o_fail_count <= fail_count;
        o_pending    <= neighbor_q.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the window gather testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_top;
    import cwg_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 3;
    localparam int NUM_REGS     = 7;
    localparam int RANDOM_ITEMS = 200;
    localparam int CALM_ITEMS   = 30;    // tail of the run with no idling at all
    localparam int DRAIN_CYCLES = 16;    // quiet cycles that count as idle
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back the block up
    localparam int HOLD_PHASE   = 2;     // random phase that gets the hold-off
    localparam int STALL_LIMIT  = 5000;  // cycles with no beat at all before giving up
    localparam int WIDTH_TOP    = (1 << WIDTH_W) - 1;

    // index that maps to no register: the write must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    localparam int   FIELD_W  [NUM_REGS] = '{WIDTH_W, HEIGHT_W, MASK_W, ROWS_W,
                                             COLS_W, ACOL_W, AROW_W};
    localparam t_pix EDGE_PIX [4]        = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};

    logic clk = 1'b0;
    logic rst_n;

    cwg_pix_if pix_bus ();
    cwg_res_if res_bus ();
    cwg_cfg_if cfg_bus ();

    int fail_count;
    int pending;

    causal_window_gather dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    cwg_gather_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_pix        (pix_bus),
        .i_res        (res_bus),
        .i_cfg        (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Register image for the next settings load; only enabled entries are written.
    logic [CFG_DATA_W-1:0] setting  [NUM_REGS];
    bit                    write_en [NUM_REGS];
    bit                    poke_none;

    logic idle_on;    // random gaps on both sides of the block
    logic hold_req;   // toggle to ask the receiver for one long hold-off

    int sent;
    int count;
    int phase;

    // ------------------------------------------------------------------
    // Receiver: random short stalls, plus one long hold-off on request.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------
    int   stall_left;
    int   hold_left;
    logic hold_seen;

    always @(posedge clk) begin
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_seen  = hold_req;
        end else begin
            if (hold_req !== hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_bus.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                // start a burst of low cycles, this one included
                stall_left = $urandom_range(0, 4);
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on any channel for too long.
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks. Each one starts right after a rising edge.
    // ------------------------------------------------------------------

    // Offer one register write and hold until the beat is taken. Leave valid
    // high so a following write does not drop it within the same step.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    endtask

    task automatic apply_settings();
        int i;
        bit wrote;
        wrote = 1'b0;
        for (i = 0; i < NUM_REGS; i++) begin
            if (write_en[i]) begin
                put_reg(CFG_IDX_W'(i), setting[i]);
                wrote = 1'b1;
            end
        end
        if (poke_none) begin
            put_reg(REG_NONE, {$urandom, $urandom});
            wrote = 1'b1;
        end
        if (wrote)
            cfg_bus.valid <= 1'b0;
    endtask

    // Load every register with the given values.
    task automatic set_all(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] m, input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] ac,
                           input logic [CFG_DATA_W-1:0] ar, input bit poke);
        int i;
        setting[REG_IMAGE_WIDTH]  = w;
        setting[REG_IMAGE_HEIGHT] = h;
        setting[REG_MASK_BITS]    = m;
        setting[REG_MASK_ROWS]    = rows;
        setting[REG_MASK_COLS]    = cols;
        setting[REG_ANCHOR_COL]   = ac;
        setting[REG_ANCHOR_ROW]   = ar;
        for (i = 0; i < NUM_REGS; i++)
            write_en[i] = 1'b1;
        poke_none = poke;
        apply_settings();
    endtask

    // Draw a random setting. Mostly small frames and typical masks, now and
    // then zero or oversize sizes; upper data bits get noise that the block
    // must drop. Dense asks for a full mask so every sample makes beats.
    task automatic randomize_settings(input bit dense);
        int i;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            setting[REG_IMAGE_WIDTH] = $urandom_range(1, 24);
        else if (pick == 7)
            setting[REG_IMAGE_WIDTH] = 0;
        else if (pick == 8)
            setting[REG_IMAGE_WIDTH] = $urandom_range(MAX_WIDTH + 1, WIDTH_TOP);
        else
            setting[REG_IMAGE_WIDTH] = $urandom_range(25, MAX_WIDTH);

        pick = $urandom_range(0, 9);
        if (pick < 7)
            setting[REG_IMAGE_HEIGHT] = $urandom_range(1, 8);
        else if (pick == 7)
            setting[REG_IMAGE_HEIGHT] = 0;
        else if (pick == 8)
            setting[REG_IMAGE_HEIGHT] = (1 << HEIGHT_W) - 1;
        else
            setting[REG_IMAGE_HEIGHT] = $urandom_range(0, (1 << HEIGHT_W) - 1);

        case ($urandom_range(0, 4))
            0:       setting[REG_MASK_BITS] = {$urandom, $urandom};
            1:       setting[REG_MASK_BITS] = {$urandom, $urandom} & {$urandom, $urandom};
            2:       setting[REG_MASK_BITS] = {$urandom, $urandom} & {$urandom, $urandom}
                                              & {$urandom, $urandom};
            3:       setting[REG_MASK_BITS] = '1;
            default: setting[REG_MASK_BITS] = 64'd1 << $urandom_range(0, MASK_W - 1);
        endcase

        setting[REG_MASK_ROWS]  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7)
                                                               : $urandom_range(1, MAX_MASK_ROWS);
        setting[REG_MASK_COLS]  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                               : $urandom_range(1, MAX_MASK_COLS);
        setting[REG_ANCHOR_COL] = $urandom_range(0, 15);
        setting[REG_ANCHOR_ROW] = $urandom_range(0, 3);

        if (dense) begin
            setting[REG_MASK_BITS]  = '1;
            setting[REG_MASK_ROWS]  = MAX_MASK_ROWS;
            setting[REG_MASK_COLS]  = MAX_MASK_COLS;
            setting[REG_ANCHOR_COL] = MAX_MASK_COLS - 1;
            setting[REG_ANCHOR_ROW] = MAX_MASK_ROWS - 1;
        end

        for (i = 0; i < NUM_REGS; i++) begin
            if ($urandom_range(0, 3) == 0)
                setting[i] = setting[i] | ({$urandom, $urandom} << FIELD_W[i]);
            write_en[i] = dense || ($urandom_range(0, 3) != 0);
        end
        poke_none = ($urandom_range(0, 5) == 0);
    endtask

    // Offer one sample, maybe after a short gap, and hold until it is taken.
    // Valid stays high so back-to-back samples need no second assignment.
    task automatic send_pixel(input t_pix value);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        pix_bus.valid       <= 1'b1;
        pix_bus.pixel_value <= value;
        do @(posedge clk); while (pix_bus.ready !== 1'b1);
    endtask

    task automatic feed_pixels(input int n, input bit edge_values);
        int k;
        for (k = 0; k < n; k++)
            send_pixel(edge_values ? EDGE_PIX[k % 4] : t_pix'($urandom));
        pix_bus.valid <= 1'b0;
    endtask

    // Wait until no beat is outstanding and the block has had time to finish
    // samples that make no beats.
    task automatic wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_CYCLES) begin
            @(posedge clk);
            quiet = (pending == 0) ? quiet + 1 : 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n               <= 1'b0;
        pix_bus.valid       <= 1'b0;
        pix_bus.pixel_value <= '0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.index       <= '0;
        cfg_bus.data        <= '0;
        hold_req            <= 1'b0;
        idle_on             <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on <= 1'b1;

        // Full mask anchored bottom right on a two-column image: neighbors left
        // of the image drop out. Extreme sample values.
        set_all(2, (1 << HEIGHT_W) - 1, '1, MAX_MASK_ROWS, MAX_MASK_COLS,
                MAX_MASK_COLS - 1, MAX_MASK_ROWS - 1, 1'b0);
        feed_pixels(8, 1'b1);
        wait_idle();

        // Oversize width and mask sizes clamp; the sixteenth sample of the row
        // sees all 64 neighbors.
        set_all(WIDTH_TOP, (1 << HEIGHT_W) - 1, '1, (1 << ROWS_W) - 1, (1 << COLS_W) - 1,
                MAX_MASK_COLS - 1, MAX_MASK_ROWS - 1, 1'b0);
        feed_pixels(16, 1'b0);
        wait_idle();

        // Zero sizes count as one: a 1x1 image, position beyond the shrunken
        // frame wraps, and a write to the unused index is ignored.
        set_all(0, 0, {$urandom, $urandom} | 64'd1, 0, 0, 0, 0, 1'b1);
        feed_pixels(2, 1'b1);
        wait_idle();

        // Anchor outside the used mask, set bits only outside it: empty vectors.
        set_all(20, 5, 64'h0000_0000_0000_FF00, 1, 4, 12, 0, 1'b0);
        feed_pixels(2, 1'b0);
        wait_idle();

        // Random phases. Drop idling for the tail of the run.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            count = (phase == HOLD_PHASE) ? 40 : $urandom_range(4, 40);
            if (count > RANDOM_ITEMS - sent)
                count = RANDOM_ITEMS - sent;
            idle_on <= (RANDOM_ITEMS - sent > CALM_ITEMS) && ($urandom_range(0, 3) != 0);
            randomize_settings(phase == HOLD_PHASE);
            apply_settings();
            if (phase == HOLD_PHASE)
                hold_req <= ~hold_req;
            feed_pixels(count, 1'b0);
            wait_idle();
            sent += count;
            phase++;
        end

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
hw/rtl/cwg_pkg.sv
hw/rtl/cwg_if.sv
hw/rtl/cwg_ram.sv
hw/rtl/cwg_front.sv
hw/rtl/cwg_queue.sv
hw/rtl/cwg_back.sv
hw/rtl/causal_window_gather.sv
tb/cwg_gather_checker.sv
tb/tb_top.sv
